@@ sv/mtsm_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Momentum to spinor matrix: shared definitions
// Field widths, fixed-point constants and the types that travel between the
// product pipeline and the element sequencer.
// ----------------------------------------------------------------------------
package mtsm_pkg;

   localparam int IN_WIDTH_DEF = 32;
   localparam int IN_FRAC_DEF  = 16;
   localparam int MOM_W        = 32;
   localparam int Q_W          = 64;
   localparam int Q_FRAC       = 32;
   localparam int POS_W        = 2;
   localparam int SQRT2_FRAC   = 30;

   // round(sqrt(2) * 2^30)
   localparam logic signed [31:0] SQRT2_Q30 = 32'sd1518500250;

   // Highest row and column index of each matrix size.
   localparam logic [POS_W-1:0] TOP_2X2 = 2'd1;
   localparam logic [POS_W-1:0] TOP_3X3 = 2'd2;

   localparam logic [Q_W-1:0] Q_MAX = {1'b0, {(Q_W-1){1'b1}}};
   localparam logic [Q_W-1:0] Q_MIN = {1'b1, {(Q_W-1){1'b0}}};

   // Fraction format of a raw element before it is brought to Q32.32.
   typedef enum logic [1:0] {
      FRAC_ONE,
      FRAC_TWO,
      FRAC_SQ
   } frac_kind_type;

   typedef struct packed {
      logic upper_index;
      logic three_dim;
   } mode_type;

endpackage

@@ sv/momentum_to_spinor_matrix_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Momentum to spinor matrix unit
// Contracts a four-momentum with the Pauli sigma matrices and streams out the
// complex 2x2 or 3x3 spin-one matrix, one element per item, in Q32.32.
// ----------------------------------------------------------------------------
// Each accepted request item carries one four-momentum (E, px, py, pz) in
// signed fixed point with IN_FRAC fraction bits (the low IN_WIDTH bits of each
// field are used and sign-extended), an upper/lower index flag and a size
// select. The unit answers with four response items for the 2x2 form or nine
// for the 3x3 spin-one form, in row-major order, each with its row, column,
// real and imaginary part in signed Q32.32, an overflow flag when a part was
// clamped to the 64-bit range, and last on the final element. Parts that drop
// fraction bits round to nearest with ties toward plus infinity. Response
// items leave at one per cycle when the receiver does not stall; the element
// sequencer, which walks the products of one momentum held in the last
// product stage, paces the stream. An item passes through four product
// stages, element selection, rounding, and the response register.
// Requests are taken while earlier items are still in flight and while a
// finished response waits to be taken. The unit keeps no state from one
// item to the next.
// ----------------------------------------------------------------------------
module momentum_to_spinor_matrix_unit #(
   parameter int IN_WIDTH = mtsm_pkg::IN_WIDTH_DEF,
   parameter int IN_FRAC  = mtsm_pkg::IN_FRAC_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic signed [mtsm_pkg::MOM_W-1:0]    req_energy,
   input  logic signed [mtsm_pkg::MOM_W-1:0]    req_mom_x,
   input  logic signed [mtsm_pkg::MOM_W-1:0]    req_mom_y,
   input  logic signed [mtsm_pkg::MOM_W-1:0]    req_mom_z,
   input  logic                                 req_upper_index,
   input  logic                                 req_three_dim,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic [mtsm_pkg::POS_W-1:0]           rsp_row,
   output logic [mtsm_pkg::POS_W-1:0]           rsp_col,
   output logic signed [mtsm_pkg::Q_W-1:0]      rsp_real_part,
   output logic signed [mtsm_pkg::Q_W-1:0]      rsp_imag_part,
   output logic                                 rsp_overflow,
   output logic                                 rsp_last
);
   import mtsm_pkg::*;

   localparam int W     = IN_WIDTH;
   localparam int F     = IN_FRAC;
   localparam int SQ_W  = 2 * W + 2;
   localparam int RAW_W = 2 * W + 32;
   // Room for the largest left shift plus the rounding carry.
   localparam int CV_W  = RAW_W + Q_FRAC + 1;

   // Shifts that bring each raw format to 32 fraction bits.
   localparam int ONE_LEFT  = Q_FRAC - F;
   localparam int F2_RIGHT  = (2 * F > Q_FRAC) ? 2 * F - Q_FRAC : 0;
   localparam int F2_LEFT   = (2 * F < Q_FRAC) ? Q_FRAC - 2 * F : 0;
   localparam int SQ_RIGHT  = 2 * F + SQRT2_FRAC - Q_FRAC;

   localparam logic signed [CV_W-1:0] HALF_TWO = (CV_W'(1) << F2_RIGHT) >> 1;
   localparam logic signed [CV_W-1:0] HALF_SQ  = (CV_W'(1) << SQ_RIGHT) >> 1;

   // Rounding increment for a format: half of the dropped weight, if any.
   function automatic logic signed [CV_W-1:0] half_of(input frac_kind_type k);
      logic signed [CV_W-1:0] h;
      case (k)
         FRAC_ONE: h = '0;
         FRAC_TWO: h = HALF_TWO;
         FRAC_SQ:  h = HALF_SQ;
         default:  h = '0;
      endcase
      return h;
   endfunction

   function automatic logic signed [CV_W-1:0] align(input logic signed [CV_W-1:0] v,
                                                    input frac_kind_type k);
      logic signed [CV_W-1:0] r;
      case (k)
         FRAC_ONE: r = v <<< ONE_LEFT;
         FRAC_TWO: r = (v >>> F2_RIGHT) <<< F2_LEFT;
         FRAC_SQ:  r = v >>> SQ_RIGHT;
         default:  r = v;
      endcase
      return r;
   endfunction

   // Returns the overflow flag above the clamped Q32.32 value.
   function automatic logic [Q_W:0] saturate(input logic signed [CV_W-1:0] v);
      logic fits;
      logic [Q_W:0] r;
      fits = (v[CV_W-1:Q_W-1] == {(CV_W-Q_W+1){v[CV_W-1]}});
      if (fits) begin
         r = {1'b0, v[Q_W-1:0]};
      end else if (v[CV_W-1]) begin
         r = {1'b1, Q_MIN};
      end else begin
         r = {1'b1, Q_MAX};
      end
      return r;
   endfunction

   // Products of the item at the head of the product pipeline.
   logic                    p_valid, p_stall;
   mode_type                req_mode, p_mode;
   logic signed [W-1:0]     p_mom_x, p_mom_y;
   logic signed [W:0]       p_c, p_d;
   logic signed [SQ_W-1:0]  p_cc, p_dd, p_mid, p_dre, p_dim;
   logic signed [RAW_W-1:0] p_cx, p_cy, p_dx, p_dy;

   // Element sequencer.
   logic [POS_W-1:0] ser_row_ff, ser_col_ff, ser_top;
   logic             ser_last, ser_step;

   // Element selection stage.
   logic                    open_elem, open_rnd, open_rsp;
   logic                    above;
   logic                    neg_re, neg_im;
   frac_kind_type           sel_kind;
   logic signed [RAW_W-1:0] sel_re, sel_im;
   logic                    elem_valid_ff, elem_last_ff;
   logic [POS_W-1:0]        elem_row_ff, elem_col_ff;
   frac_kind_type           elem_kind_ff;
   logic signed [RAW_W-1:0] elem_re_ff, elem_im_ff, elem_re_in, elem_im_in;

   // Rounding stage.
   logic                    rnd_valid_ff, rnd_last_ff;
   logic [POS_W-1:0]        rnd_row_ff, rnd_col_ff;
   frac_kind_type           rnd_kind_ff;
   logic signed [CV_W-1:0]  rnd_re_ff, rnd_im_ff, rnd_re_in, rnd_im_in;

   // Response register.
   logic [Q_W:0]            sat_re, sat_im;
   logic                    rsp_valid_ff, rsp_last_ff, rsp_overflow_ff;
   logic [POS_W-1:0]        rsp_row_ff, rsp_col_ff;
   logic signed [Q_W-1:0]   rsp_real_ff, rsp_imag_ff;

   assign req_mode.upper_index = req_upper_index;
   assign req_mode.three_dim   = req_three_dim;

   mtsm_products #(
      .IN_WIDTH (IN_WIDTH)
   ) u_products (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_stall  (req_stall),
      .in_energy (req_energy),
      .in_mom_x  (req_mom_x),
      .in_mom_y  (req_mom_y),
      .in_mom_z  (req_mom_z),
      .in_mode   (req_mode),
      .out_valid (p_valid),
      .out_stall (p_stall),
      .out_mode  (p_mode),
      .out_mom_x (p_mom_x),
      .out_mom_y (p_mom_y),
      .out_c     (p_c),
      .out_d     (p_d),
      .out_cc    (p_cc),
      .out_dd    (p_dd),
      .out_mid   (p_mid),
      .out_dre   (p_dre),
      .out_dim   (p_dim),
      .out_cx    (p_cx),
      .out_cy    (p_cy),
      .out_dx    (p_dx),
      .out_dy    (p_dy)
   );

   // Each stage loads when it is empty or its content moves on this cycle.
   assign open_rsp  = !rsp_valid_ff || !rsp_stall;
   assign open_rnd  = !rnd_valid_ff || open_rsp;
   assign open_elem = !elem_valid_ff || open_rnd;

   // The sequencer walks row by row over the held products. The product
   // stage is released only as its final element moves into selection.
   assign ser_top  = p_mode.three_dim ? TOP_3X3 : TOP_2X2;
   assign ser_last = (ser_row_ff == ser_top) && (ser_col_ff == ser_top);
   assign ser_step = p_valid && open_elem;
   assign p_stall  = !(open_elem && ser_last);

   always_ff @(posedge clock) begin
      if (reset) begin
         ser_row_ff <= '0;
         ser_col_ff <= '0;
      end else if (ser_step) begin
         if (ser_last) begin
            ser_row_ff <= '0;
            ser_col_ff <= '0;
         end else if (ser_col_ff == ser_top) begin
            ser_row_ff <= ser_row_ff + 1'b1;
            ser_col_ff <= '0;
         end else begin
            ser_col_ff <= ser_col_ff + 1'b1;
         end
      end
   end

   // Pick the raw parts of the current element. Off-diagonal imaginary parts
   // flip sign between the upper and lower triangle; the index form flips
   // the sign of the px +/- i*py terms.
   always_comb begin
      sel_re   = '0;
      sel_im   = '0;
      neg_re   = 1'b0;
      neg_im   = 1'b0;
      sel_kind = FRAC_ONE;
      above    = ser_col_ff > ser_row_ff;
      if (!p_mode.three_dim) begin
         sel_kind = FRAC_ONE;
         if (ser_row_ff == ser_col_ff) begin
            sel_re = (ser_row_ff == '0) ? RAW_W'(p_c) : RAW_W'(p_d);
         end else begin
            sel_re = RAW_W'(p_mom_x);
            neg_re = p_mode.upper_index;
            sel_im = RAW_W'(p_mom_y);
            neg_im = p_mode.upper_index ^ above;
         end
      end else if (ser_row_ff == ser_col_ff) begin
         sel_kind = FRAC_TWO;
         sel_re   = (ser_row_ff == '0)      ? RAW_W'(p_cc) :
                    (ser_row_ff == TOP_3X3) ? RAW_W'(p_dd) : RAW_W'(p_mid);
      end else if ((ser_row_ff == '0 && ser_col_ff == TOP_3X3) ||
                   (ser_row_ff == TOP_3X3 && ser_col_ff == '0)) begin
         // Corners carry (px -/+ i*py) squared.
         sel_kind = FRAC_TWO;
         sel_re   = RAW_W'(p_dre);
         sel_im   = RAW_W'(p_dim);
         neg_im   = above;
      end else begin
         // Next to the first row or column the weight is c, otherwise d.
         sel_kind = FRAC_SQ;
         if (ser_row_ff == '0 || ser_col_ff == '0) begin
            sel_re = p_cx;
            sel_im = p_cy;
         end else begin
            sel_re = p_dx;
            sel_im = p_dy;
         end
         neg_re = p_mode.upper_index;
         neg_im = p_mode.upper_index ^ above;
      end
      elem_re_in = neg_re ? -sel_re : sel_re;
      elem_im_in = neg_im ? -sel_im : sel_im;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         elem_valid_ff <= 1'b0;
      end else if (open_elem) begin
         elem_valid_ff <= p_valid;
      end
      if (open_elem) begin
         elem_row_ff  <= ser_row_ff;
         elem_col_ff  <= ser_col_ff;
         elem_last_ff <= ser_last;
         elem_kind_ff <= sel_kind;
         elem_re_ff   <= elem_re_in;
         elem_im_ff   <= elem_im_in;
      end
   end

   // Add half of the weight that the alignment shift will drop.
   always_comb begin
      rnd_re_in = CV_W'(elem_re_ff) + half_of(elem_kind_ff);
      rnd_im_in = CV_W'(elem_im_ff) + half_of(elem_kind_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rnd_valid_ff <= 1'b0;
      end else if (open_rnd) begin
         rnd_valid_ff <= elem_valid_ff;
      end
      if (open_rnd) begin
         rnd_row_ff  <= elem_row_ff;
         rnd_col_ff  <= elem_col_ff;
         rnd_last_ff <= elem_last_ff;
         rnd_kind_ff <= elem_kind_ff;
         rnd_re_ff   <= rnd_re_in;
         rnd_im_ff   <= rnd_im_in;
      end
   end

   // Align to Q32.32 and clamp to the 64-bit range.
   always_comb begin
      sat_re = saturate(align(rnd_re_ff, rnd_kind_ff));
      sat_im = saturate(align(rnd_im_ff, rnd_kind_ff));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (open_rsp) begin
         rsp_valid_ff <= rnd_valid_ff;
      end
      if (open_rsp) begin
         rsp_row_ff      <= rnd_row_ff;
         rsp_col_ff      <= rnd_col_ff;
         rsp_last_ff     <= rnd_last_ff;
         rsp_real_ff     <= sat_re[Q_W-1:0];
         rsp_imag_ff     <= sat_im[Q_W-1:0];
         rsp_overflow_ff <= sat_re[Q_W] | sat_im[Q_W];
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_row       = rsp_row_ff;
   assign rsp_col       = rsp_col_ff;
   assign rsp_real_part = rsp_real_ff;
   assign rsp_imag_part = rsp_imag_ff;
   assign rsp_overflow  = rsp_overflow_ff;
   assign rsp_last      = rsp_last_ff;

endmodule

@@ sv/mtsm_products.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Momentum to spinor matrix: product pipeline
// Four register stages that form every exact product and sum one momentum
// needs. The last stage doubles as the holding register for the sequencer.
// ----------------------------------------------------------------------------
module mtsm_products #(
   parameter int IN_WIDTH = mtsm_pkg::IN_WIDTH_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 in_valid,
   output logic                                 in_stall,
   input  logic signed [mtsm_pkg::MOM_W-1:0]    in_energy,
   input  logic signed [mtsm_pkg::MOM_W-1:0]    in_mom_x,
   input  logic signed [mtsm_pkg::MOM_W-1:0]    in_mom_y,
   input  logic signed [mtsm_pkg::MOM_W-1:0]    in_mom_z,
   input  mtsm_pkg::mode_type                   in_mode,
   output logic                                 out_valid,
   input  logic                                 out_stall,
   output mtsm_pkg::mode_type                   out_mode,
   output logic signed [IN_WIDTH-1:0]           out_mom_x,
   output logic signed [IN_WIDTH-1:0]           out_mom_y,
   output logic signed [IN_WIDTH:0]             out_c,
   output logic signed [IN_WIDTH:0]             out_d,
   output logic signed [2*IN_WIDTH+1:0]         out_cc,
   output logic signed [2*IN_WIDTH+1:0]         out_dd,
   output logic signed [2*IN_WIDTH+1:0]         out_mid,
   output logic signed [2*IN_WIDTH+1:0]         out_dre,
   output logic signed [2*IN_WIDTH+1:0]         out_dim,
   output logic signed [2*IN_WIDTH+31:0]        out_cx,
   output logic signed [2*IN_WIDTH+31:0]        out_cy,
   output logic signed [2*IN_WIDTH+31:0]        out_dx,
   output logic signed [2*IN_WIDTH+31:0]        out_dy
);
   import mtsm_pkg::*;

   localparam int W       = IN_WIDTH;
   localparam int SQ_W    = 2 * W + 2;
   localparam int CS_W    = W + 32;
   localparam int SPLIT_W = 32;
   localparam int RAW_W   = 2 * W + 32;

   logic open1, open2, open3, open4;

   // Stage 1: sign-extended inputs and E +/- pz.
   logic                 v1_ff;
   mode_type             mode1_ff;
   logic signed [W-1:0]  e1_ff, x1_ff, y1_ff, z1_ff;
   logic signed [W:0]    c1_ff, d1_ff;
   logic signed [W:0]    sum_a, sum_b, c1_in, d1_in;

   // Stage 2: squares, cross product and the sqrt(2) weighted c and d.
   logic                 v2_ff;
   mode_type             mode2_ff;
   logic signed [W-1:0]  x2_ff, y2_ff;
   logic signed [W:0]    c2_ff, d2_ff;
   logic signed [SQ_W-1:0] cc2_ff, dd2_ff, cc2_in, dd2_in;
   logic signed [2*W-1:0]  ee2_ff, xx2_ff, yy2_ff, zz2_ff, xy2_ff;
   logic signed [2*W-1:0]  ee2_in, xx2_in, yy2_in, zz2_in, xy2_in;
   logic signed [CS_W:0]   cs_full, ds_full;
   logic signed [CS_W-1:0] cs2_ff, ds2_ff;

   // Stage 3: partial sums and 32-bit partial products of the weighted terms.
   logic                 v3_ff;
   mode_type             mode3_ff;
   logic signed [W-1:0]  x3_ff, y3_ff;
   logic signed [W:0]    c3_ff, d3_ff;
   logic signed [SQ_W-1:0] cc3_ff, dd3_ff, s1_3_ff, s2_3_ff, dre3_ff, dim3_ff;
   logic signed [SQ_W-1:0] s1_3_in, s2_3_in, dre3_in, dim3_in;
   logic signed [W+SPLIT_W:0] cxl3_ff, cyl3_ff, dxl3_ff, dyl3_ff;
   logic signed [W+SPLIT_W:0] cxl3_in, cyl3_in, dxl3_in, dyl3_in;
   logic signed [2*W-1:0]     cxh3_ff, cyh3_ff, dxh3_ff, dyh3_ff;
   logic signed [2*W-1:0]     cxh3_in, cyh3_in, dxh3_in, dyh3_in;

   // Stage 4: final products, held while the elements go out.
   logic                 v4_ff;
   mode_type             mode4_ff;
   logic signed [W-1:0]  x4_ff, y4_ff;
   logic signed [W:0]    c4_ff, d4_ff;
   logic signed [SQ_W-1:0]  cc4_ff, dd4_ff, mid4_ff, dre4_ff, dim4_ff, mid4_in;
   logic signed [RAW_W-1:0] cx4_ff, cy4_ff, dx4_ff, dy4_ff;
   logic signed [RAW_W-1:0] cx4_in, cy4_in, dx4_in, dy4_in;

   assign open4    = !v4_ff || !out_stall;
   assign open3    = !v3_ff || open4;
   assign open2    = !v2_ff || open3;
   assign open1    = !v1_ff || open2;
   assign in_stall = !open1;

   always_comb begin
      sum_a = {in_energy[W-1], in_energy[W-1:0]} + {in_mom_z[W-1], in_mom_z[W-1:0]};
      sum_b = {in_energy[W-1], in_energy[W-1:0]} - {in_mom_z[W-1], in_mom_z[W-1:0]};
      c1_in = in_mode.upper_index ? sum_b : sum_a;
      d1_in = in_mode.upper_index ? sum_a : sum_b;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else if (open1) begin
         v1_ff <= in_valid;
      end
      if (open1) begin
         mode1_ff <= in_mode;
         e1_ff    <= in_energy[W-1:0];
         x1_ff    <= in_mom_x[W-1:0];
         y1_ff    <= in_mom_y[W-1:0];
         z1_ff    <= in_mom_z[W-1:0];
         c1_ff    <= c1_in;
         d1_ff    <= d1_in;
      end
   end

   always_comb begin
      cc2_in  = c1_ff * c1_ff;
      dd2_in  = d1_ff * d1_ff;
      ee2_in  = e1_ff * e1_ff;
      xx2_in  = x1_ff * x1_ff;
      yy2_in  = y1_ff * y1_ff;
      zz2_in  = z1_ff * z1_ff;
      xy2_in  = x1_ff * y1_ff;
      cs_full = c1_ff * SQRT2_Q30;
      ds_full = d1_ff * SQRT2_Q30;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
      end else if (open2) begin
         v2_ff <= v1_ff;
      end
      if (open2) begin
         mode2_ff <= mode1_ff;
         x2_ff    <= x1_ff;
         y2_ff    <= y1_ff;
         c2_ff    <= c1_ff;
         d2_ff    <= d1_ff;
         cc2_ff   <= cc2_in;
         dd2_ff   <= dd2_in;
         ee2_ff   <= ee2_in;
         xx2_ff   <= xx2_in;
         yy2_ff   <= yy2_in;
         zz2_ff   <= zz2_in;
         xy2_ff   <= xy2_in;
         cs2_ff   <= cs_full[CS_W-1:0];
         ds2_ff   <= ds_full[CS_W-1:0];
      end
   end

   always_comb begin
      s1_3_in = SQ_W'(ee2_ff) + SQ_W'(xx2_ff);
      s2_3_in = SQ_W'(yy2_ff) - SQ_W'(zz2_ff);
      dre3_in = SQ_W'(xx2_ff) - SQ_W'(yy2_ff);
      dim3_in = SQ_W'(xy2_ff) <<< 1;
      cxl3_in = $signed({1'b0, cs2_ff[SPLIT_W-1:0]}) * x2_ff;
      cyl3_in = $signed({1'b0, cs2_ff[SPLIT_W-1:0]}) * y2_ff;
      dxl3_in = $signed({1'b0, ds2_ff[SPLIT_W-1:0]}) * x2_ff;
      dyl3_in = $signed({1'b0, ds2_ff[SPLIT_W-1:0]}) * y2_ff;
      cxh3_in = $signed(cs2_ff[CS_W-1:SPLIT_W]) * x2_ff;
      cyh3_in = $signed(cs2_ff[CS_W-1:SPLIT_W]) * y2_ff;
      dxh3_in = $signed(ds2_ff[CS_W-1:SPLIT_W]) * x2_ff;
      dyh3_in = $signed(ds2_ff[CS_W-1:SPLIT_W]) * y2_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v3_ff <= 1'b0;
      end else if (open3) begin
         v3_ff <= v2_ff;
      end
      if (open3) begin
         mode3_ff <= mode2_ff;
         x3_ff    <= x2_ff;
         y3_ff    <= y2_ff;
         c3_ff    <= c2_ff;
         d3_ff    <= d2_ff;
         cc3_ff   <= cc2_ff;
         dd3_ff   <= dd2_ff;
         s1_3_ff  <= s1_3_in;
         s2_3_ff  <= s2_3_in;
         dre3_ff  <= dre3_in;
         dim3_ff  <= dim3_in;
         cxl3_ff  <= cxl3_in;
         cyl3_ff  <= cyl3_in;
         dxl3_ff  <= dxl3_in;
         dyl3_ff  <= dyl3_in;
         cxh3_ff  <= cxh3_in;
         cyh3_ff  <= cyh3_in;
         dxh3_ff  <= dxh3_in;
         dyh3_ff  <= dyh3_in;
      end
   end

   always_comb begin
      mid4_in = s1_3_ff + s2_3_ff;
      cx4_in  = (RAW_W'(cxh3_ff) <<< SPLIT_W) + RAW_W'(cxl3_ff);
      cy4_in  = (RAW_W'(cyh3_ff) <<< SPLIT_W) + RAW_W'(cyl3_ff);
      dx4_in  = (RAW_W'(dxh3_ff) <<< SPLIT_W) + RAW_W'(dxl3_ff);
      dy4_in  = (RAW_W'(dyh3_ff) <<< SPLIT_W) + RAW_W'(dyl3_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v4_ff <= 1'b0;
      end else if (open4) begin
         v4_ff <= v3_ff;
      end
      if (open4) begin
         mode4_ff <= mode3_ff;
         x4_ff    <= x3_ff;
         y4_ff    <= y3_ff;
         c4_ff    <= c3_ff;
         d4_ff    <= d3_ff;
         cc4_ff   <= cc3_ff;
         dd4_ff   <= dd3_ff;
         mid4_ff  <= mid4_in;
         dre4_ff  <= dre3_ff;
         dim4_ff  <= dim3_ff;
         cx4_ff   <= cx4_in;
         cy4_ff   <= cy4_in;
         dx4_ff   <= dx4_in;
         dy4_ff   <= dy4_in;
      end
   end

   assign out_valid = v4_ff;
   assign out_mode  = mode4_ff;
   assign out_mom_x = x4_ff;
   assign out_mom_y = y4_ff;
   assign out_c     = c4_ff;
   assign out_d     = d4_ff;
   assign out_cc    = cc4_ff;
   assign out_dd    = dd4_ff;
   assign out_mid   = mid4_ff;
   assign out_dre   = dre4_ff;
   assign out_dim   = dim4_ff;
   assign out_cx    = cx4_ff;
   assign out_cy    = cy4_ff;
   assign out_dx    = dx4_ff;
   assign out_dy    = dy4_ff;

endmodule

@@ verif/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Momentum to spinor matrix unit testbench
// Drives four-momentum items into the unit, predicts every matrix element
// from its own wide-integer model of p.sigma, and checks the response stream
// element by element under random gaps, random back-pressure and long holds.
// ----------------------------------------------------------------------------
module tb_top;
   import mtsm_pkg::*;

   // The unit runs at its default widths. Every momentum port is MOM_W bits
   // wide and IN_WIDTH matches it, so no input bits are dropped before the
   // sign extension.
   localparam int FRAC_BITS     = IN_FRAC_DEF;
   localparam int LONG_HOLD     = 150;
   localparam int SETTLE_CYCLES = 20;
   localparam int RANDOM_ITEMS  = 420;
   localparam int RUN_LIMIT_NS  = 3000000;

   localparam logic signed [31:0] MOM_MAX = 32'sh7FFF_FFFF;
   localparam logic signed [31:0] MOM_MIN = 32'sh8000_0000;

   // Wide enough to hold every exact product of the spin-one form.
   typedef logic signed [127:0] acc_type;

   typedef struct packed {
      logic signed [Q_W-1:0] value;
      logic                  clamped;
   } q32_type;

   typedef struct {
      logic [POS_W-1:0]      row;
      logic [POS_W-1:0]      col;
      logic signed [Q_W-1:0] real_part;
      logic signed [Q_W-1:0] imag_part;
      logic                  overflow;
      logic                  last;
   } element_type;

   logic                    clock = 1'b0;
   logic                    reset;
   logic                    req_valid;
   logic                    req_stall;
   logic signed [MOM_W-1:0] req_energy;
   logic signed [MOM_W-1:0] req_mom_x;
   logic signed [MOM_W-1:0] req_mom_y;
   logic signed [MOM_W-1:0] req_mom_z;
   logic                    req_upper_index;
   logic                    req_three_dim;
   logic                    rsp_valid;
   logic                    rsp_stall;
   logic [POS_W-1:0]        rsp_row;
   logic [POS_W-1:0]        rsp_col;
   logic signed [Q_W-1:0]   rsp_real_part;
   logic signed [Q_W-1:0]   rsp_imag_part;
   logic                    rsp_overflow;
   logic                    rsp_last;

   // Elements predicted for accepted items and not yet seen on the output,
   // oldest first.
   element_type pending_elements[$];

   int mismatch_count  = 0;
   int elements_seen   = 0;
   int saturated_seen  = 0;
   int items_2x2       = 0;
   int items_3x3       = 0;
   int items_upper     = 0;

   // Flags shared between the test sequence and the response driver.
   bit sender_calm   = 1'b0;
   bit rsp_calm      = 1'b0;
   bit hold_request  = 1'b0;
   bit hold_active   = 1'b0;

   momentum_to_spinor_matrix_unit dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_energy      (req_energy),
      .req_mom_x       (req_mom_x),
      .req_mom_y       (req_mom_y),
      .req_mom_z       (req_mom_z),
      .req_upper_index (req_upper_index),
      .req_three_dim   (req_three_dim),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_row         (rsp_row),
      .rsp_col         (rsp_col),
      .rsp_real_part   (rsp_real_part),
      .rsp_imag_part   (rsp_imag_part),
      .rsp_overflow    (rsp_overflow),
      .rsp_last        (rsp_last)
   );

   always #1 clock = ~clock;

   // -------------------------------------------------------------------------
   // Prediction
   // -------------------------------------------------------------------------

   // Brings an exact part with the given fraction format to Q32.32. Parts
   // with more than 32 fraction bits round to nearest, ties upward; anything
   // outside the signed 64-bit range is clamped.
   function automatic q32_type scale_to_q32(acc_type v, frac_kind_type kind);
      int      frac;
      acc_type s;
      q32_type q;
      case (kind)
         FRAC_ONE: frac = FRAC_BITS;
         FRAC_TWO: frac = 2 * FRAC_BITS;
         default:  frac = 2 * FRAC_BITS + SQRT2_FRAC;
      endcase
      if (frac > Q_FRAC) begin
         s = (v + (acc_type'(1) <<< (frac - Q_FRAC - 1))) >>> (frac - Q_FRAC);
      end else begin
         s = v <<< (Q_FRAC - frac);
      end
      q.clamped = (s[127:63] != {65{s[63]}});
      q.value   = q.clamped ? (s[127] ? Q_MIN : Q_MAX) : s[63:0];
      return q;
   endfunction

   function automatic void push_element(int row, int col, acc_type re,
                                        frac_kind_type re_kind, acc_type im,
                                        frac_kind_type im_kind, bit last);
      q32_type     qr;
      q32_type     qi;
      element_type el;
      qr = scale_to_q32(re, re_kind);
      qi = scale_to_q32(im, im_kind);
      el.row       = POS_W'(row);
      el.col       = POS_W'(col);
      el.real_part = qr.value;
      el.imag_part = qi.value;
      el.overflow  = qr.clamped | qi.clamped;
      el.last      = last;
      pending_elements.push_back(el);
   endfunction

   // Appends the elements of p.sigma for one momentum, in row-major order.
   // The sign of each part is applied before it is rounded.
   function automatic void predict_sigma_matrix(logic signed [31:0] e,
                                                logic signed [31:0] px,
                                                logic signed [31:0] py,
                                                logic signed [31:0] pz,
                                                logic up, logic three);
      acc_type ew, xw, yw, zw, sum, dif, c, d, r2, cs, ds;
      acc_type px2, py2, dre, dim, mid, cx, cy, dx, dy;
      ew  = e;
      xw  = px;
      yw  = py;
      zw  = pz;
      sum = ew + zw;
      dif = ew - zw;
      // Upper index swaps the diagonal and flips the sign of the off-diagonal terms linear in px and py.
      c   = up ? dif : sum;
      d   = up ? sum : dif;
      if (!three) begin
         push_element(0, 0, c, FRAC_ONE, 0, FRAC_ONE, 1'b0);
         push_element(0, 1, up ? -xw : xw, FRAC_ONE, up ? yw : -yw, FRAC_ONE, 1'b0);
         push_element(1, 0, up ? -xw : xw, FRAC_ONE, up ? -yw : yw, FRAC_ONE, 1'b0);
         push_element(1, 1, d, FRAC_ONE, 0, FRAC_ONE, 1'b1);
      end else begin
         r2  = SQRT2_Q30;
         cs  = c * r2;
         ds  = d * r2;
         px2 = xw * xw;
         py2 = yw * yw;
         dre = px2 - py2;
         dim = (xw * yw) <<< 1;
         mid = ew * ew + px2 + py2 - zw * zw;
         cx  = cs * xw;
         cy  = cs * yw;
         dx  = ds * xw;
         dy  = ds * yw;
         push_element(0, 0, c * c, FRAC_TWO, 0, FRAC_TWO, 1'b0);
         push_element(0, 1, up ? -cx : cx, FRAC_SQ, up ? cy : -cy, FRAC_SQ, 1'b0);
         push_element(0, 2, dre, FRAC_TWO, -dim, FRAC_TWO, 1'b0);
         push_element(1, 0, up ? -cx : cx, FRAC_SQ, up ? -cy : cy, FRAC_SQ, 1'b0);
         push_element(1, 1, mid, FRAC_TWO, 0, FRAC_TWO, 1'b0);
         push_element(1, 2, up ? -dx : dx, FRAC_SQ, up ? dy : -dy, FRAC_SQ, 1'b0);
         push_element(2, 0, dre, FRAC_TWO, dim, FRAC_TWO, 1'b0);
         push_element(2, 1, up ? -dx : dx, FRAC_SQ, up ? -dy : dy, FRAC_SQ, 1'b0);
         push_element(2, 2, d * d, FRAC_TWO, 0, FRAC_TWO, 1'b1);
      end
   endfunction

   // -------------------------------------------------------------------------
   // Random helpers
   // -------------------------------------------------------------------------

   // Sender gap: half the time none, mostly short, now and then long.
   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 50) return 0;
      if (roll < 85) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   // A momentum component: full-range bits, small magnitudes that keep the
   // spin-one products away from saturation, or one of the corner values.
   function automatic logic signed [31:0] pick_component();
      logic signed [31:0] v;
      case ($urandom_range(0, 9))
         0, 1, 2, 3: v = $urandom;
         4, 5, 6, 7: begin
            v = $urandom_range(0, 32'h0020_0000);
            v = v - 32'sh0010_0000;
         end
         default: begin
            case ($urandom_range(0, 4))
               0:       v = 32'sd0;
               1:       v = 32'sd1;
               2:       v = -32'sd1;
               3:       v = MOM_MAX;
               default: v = MOM_MIN;
            endcase
         end
      endcase
      return v;
   endfunction

   // -------------------------------------------------------------------------
   // Request side
   // -------------------------------------------------------------------------

   // Offers one item and holds it until the unit takes it. Valid is left
   // high when the next item follows with no gap, so it never drops and
   // rises in the same time step.
   task automatic send_momentum(input logic signed [31:0] e, px, py, pz,
                                input logic up, three);
      int gap;
      req_valid       <= 1'b1;
      req_energy      <= e;
      req_mom_x       <= px;
      req_mom_y       <= py;
      req_mom_z       <= pz;
      req_upper_index <= up;
      req_three_dim   <= three;
      do @(posedge clock); while (req_stall);
      predict_sigma_matrix(e, px, py, pz, up, three);
      if (three) items_3x3++;
      else items_2x2++;
      if (up) items_upper++;
      gap = sender_calm ? 0 : pick_gap();
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // Takes the sender off the channel and waits until every predicted
   // element has been checked.
   task automatic wait_drained();
      req_valid <= 1'b0;
      while (pending_elements.size() != 0) @(posedge clock);
   endtask

   // -------------------------------------------------------------------------
   // Tests
   // -------------------------------------------------------------------------

   // One ordinary momentum through both sizes and both index positions.
   task automatic test_matrix_forms();
      for (int k = 0; k < 4; k++) begin
         send_momentum(32'sh0005_0000, 32'sh0001_4000, -32'sh0000_C000,
                       32'sh0002_8000, k[0], k[1]);
      end
   endtask

   // Zero, full-scale and alternating components, and the smallest steps.
   task automatic test_field_extremes();
      send_momentum(32'sd0, 32'sd0, 32'sd0, 32'sd0, 1'b0, 1'b0);
      send_momentum(MOM_MAX, MOM_MAX, MOM_MAX, MOM_MAX, 1'b1, 1'b0);
      send_momentum(MOM_MIN, MOM_MIN, MOM_MIN, MOM_MIN, 1'b0, 1'b0);
      send_momentum(MOM_MAX, MOM_MIN, MOM_MAX, MOM_MIN, 1'b0, 1'b1);
      send_momentum(32'sd1, -32'sd1, 32'sd1, -32'sd1, 1'b1, 1'b1);
      send_momentum(32'sd0, 32'sd0, 32'sd0, 32'sd0, 1'b1, 1'b1);
   endtask

   // Off-diagonal spin-one terms whose dropped bits are exactly one half,
   // with positive and negative sign, so the tie goes toward plus infinity.
   task automatic test_rounding_ties();
      send_momentum(32'sh1000_0000, 32'sd1, -32'sd1, 32'sd0, 1'b0, 1'b1);
      send_momentum(32'sh1000_0000, 32'sd1, -32'sd1, 32'sd0, 1'b1, 1'b1);
      send_momentum(32'sh1000_0000, 32'sd3, -32'sd5, 32'sd0, 1'b0, 1'b1);
      send_momentum(32'sh0800_0000, -32'sd1, 32'sd1, 32'sh0800_0000, 1'b1, 1'b1);
   endtask

   // Spin-one momenta whose squares and cross terms leave the 64-bit range.
   task automatic test_saturation();
      send_momentum(MOM_MIN, MOM_MIN, MOM_MIN, MOM_MIN, 1'b0, 1'b1);
      send_momentum(MOM_MAX, MOM_MAX, MOM_MAX, MOM_MIN, 1'b1, 1'b1);
      send_momentum(MOM_MIN, MOM_MAX, MOM_MIN, MOM_MAX, 1'b1, 1'b1);
   endtask

   // The receiver holds off for a long stretch while items keep coming back
   // to back, so the unit fills up and has to stall its input.
   task automatic test_backpressure();
      wait_drained();
      hold_request = 1'b1;
      while (!hold_active) @(posedge clock);
      sender_calm = 1'b1;
      for (int k = 0; k < 16; k++) begin
         send_momentum(pick_component(), pick_component(), pick_component(),
                       pick_component(), $urandom_range(0, 1), $urandom_range(0, 1));
      end
      sender_calm = 1'b0;
      wait_drained();
   endtask

   // Random momenta and flags. Every so often the sender waits for the unit
   // to empty before it resumes, and some stretches run with neither side
   // idling.
   task automatic test_random_stream();
      for (int k = 0; k < RANDOM_ITEMS; k++) begin
         if (k % 70 == 69) wait_drained();
         sender_calm = (k % 100 >= 40) && (k % 100 < 60);
         rsp_calm    = sender_calm;
         send_momentum(pick_component(), pick_component(), pick_component(),
                       pick_component(), $urandom_range(0, 1), $urandom_range(0, 1));
      end
      sender_calm = 1'b0;
      rsp_calm    = 1'b0;
   endtask

   // -------------------------------------------------------------------------
   // Response side
   // -------------------------------------------------------------------------

   // Drives rsp_stall in spans of random length. A long hold requested by a
   // test is counted out here, in cycles, independent of the sender.
   initial begin : rsp_driver
      int span;
      bit hold;
      forever begin
         if (hold_request) begin
            hold_request = 1'b0;
            hold_active  = 1'b1;
            hold         = 1'b1;
            span         = LONG_HOLD;
         end else begin
            hold_active = 1'b0;
            hold        = !rsp_calm && ($urandom_range(0, 2) == 0);
            if (!hold) span = $urandom_range(1, 6);
            else if ($urandom_range(0, 99) < 85) span = $urandom_range(1, 3);
            else span = $urandom_range(10, 40);
         end
         rsp_stall <= hold;
         repeat (span) @(posedge clock);
      end
   end

   // Every element the unit hands over is compared with the oldest
   // prediction. Anything that arrives with nothing predicted is a failure.
   always @(posedge clock) begin
      element_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         elements_seen++;
         if (rsp_overflow === 1'b1) saturated_seen++;
         if (pending_elements.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10) begin
               $display("ERROR: element %0d/%0d arrived with no item outstanding",
                        rsp_row, rsp_col);
            end
         end else begin
            want = pending_elements.pop_front();
            if (rsp_row !== want.row || rsp_col !== want.col ||
                rsp_real_part !== want.real_part ||
                rsp_imag_part !== want.imag_part ||
                rsp_overflow !== want.overflow || rsp_last !== want.last) begin
               mismatch_count++;
               if (mismatch_count <= 10) begin
                  $display("ERROR: element expected %0d/%0d re %h im %h ovf %b last %b",
                           want.row, want.col, want.real_part, want.imag_part,
                           want.overflow, want.last);
                  $display("              actual %0d/%0d re %h im %h ovf %b last %b",
                           rsp_row, rsp_col, rsp_real_part, rsp_imag_part,
                           rsp_overflow, rsp_last);
               end
            end
         end
      end
   end

   // -------------------------------------------------------------------------
   // Sequence
   // -------------------------------------------------------------------------

   initial begin : run_tests
      reset           <= 1'b1;
      req_valid       <= 1'b0;
      req_energy      <= '0;
      req_mom_x       <= '0;
      req_mom_y       <= '0;
      req_mom_z       <= '0;
      req_upper_index <= 1'b0;
      req_three_dim   <= 1'b0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      test_matrix_forms();
      test_field_extremes();
      test_rounding_ties();
      test_saturation();
      test_backpressure();
      test_random_stream();

      // Let any stray element show up before the verdict.
      wait_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);

      $display("Covered %0d 2x2 and %0d spin-one matrices, %0d with upper index,",
               items_2x2, items_3x3, items_upper);
      $display("checking %0d elements of which %0d saturated; %0d mismatches.",
               elements_seen, saturated_seen, mismatch_count);
      if (mismatch_count == 0) begin
         $display("momentum_to_spinor_matrix_unit verification clean");
      end else begin
         $display("momentum_to_spinor_matrix_unit verification failed");
      end
      $finish;
   end

   // A hung handshake or a lost element ends the run here.
   initial begin : watchdog
      #RUN_LIMIT_NS;
      $display("momentum_to_spinor_matrix_unit verification failed");
      $finish;
   end

endmodule
